### design/tun_pkg.sv
// Package for the triangle unit normal block.
// Shared constants and codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tun_pkg;
  localparam int MAG_W  = 31;  // normalized magnitude, top bit at 30
  localparam int SUM_W  = 64;  // sum of squares
  localparam int ROOT_W = 32;  // integer square root
  localparam logic KIND_VECTORS  = 1'b0;
  localparam logic KIND_TRIANGLE = 1'b1;
endpackage
`default_nettype wire

### design/tun_cross.sv
// Edge vectors (or the vectors as given), partial products and exact cross product, three stages.
// Depends on tun_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tun_cross import tun_pkg::*; #(
  parameter int CW = 32
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  en,
  input  wire                  in_valid,
  input  wire                  kind,
  input  wire [9*CW-1:0]       pts,
  output logic                 out_valid,
  output logic signed [2*CW+2:0] c0,
  output logic signed [2*CW+2:0] c1,
  output logic signed [2*CW+2:0] c2
);
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * CW + 2;
  localparam int CXW = 2 * CW + 3;

  logic signed [DW-1:0] pt [9];
  logic signed [DW-1:0] a_next [3];
  logic signed [DW-1:0] b_next [3];
  logic signed [DW-1:0] a [3];
  logic signed [DW-1:0] b [3];
  logic signed [PW-1:0] pr [6];
  logic v1, v2;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      pt[i] = $signed({pts[i*CW+CW-1], pts[i*CW +: CW]});
    end
    for (int i = 0; i < 3; i++) begin
      if (kind == KIND_TRIANGLE) begin
        a_next[i] = pt[3+i] - pt[i];
        b_next[i] = pt[6+i] - pt[i];
      end else begin
        a_next[i] = pt[i];
        b_next[i] = pt[3+i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a <= a_next;
      b <= b_next;
      pr[0] <= PW'(a[1]) * PW'(b[2]);
      pr[1] <= PW'(a[2]) * PW'(b[1]);
      pr[2] <= PW'(a[2]) * PW'(b[0]);
      pr[3] <= PW'(a[0]) * PW'(b[2]);
      pr[4] <= PW'(a[0]) * PW'(b[1]);
      pr[5] <= PW'(a[1]) * PW'(b[0]);
      c0 <= CXW'(pr[0]) - CXW'(pr[1]);
      c1 <= CXW'(pr[2]) - CXW'(pr[3]);
      c2 <= CXW'(pr[4]) - CXW'(pr[5]);
    end
  end
endmodule
`default_nettype wire

### design/tun_norm.sv
// Magnitudes, leading-one search, normalizing shift and sum of squares.
// Five stages; depends on tun_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tun_norm import tun_pkg::*; #(
  parameter int CW = 32
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    en,
  input  wire                    in_valid,
  input  wire signed [2*CW+2:0]  c0,
  input  wire signed [2*CW+2:0]  c1,
  input  wire signed [2*CW+2:0]  c2,
  output logic                   out_valid,
  output logic [3*MAG_W-1:0]     m_out,
  output logic [2:0]             neg_out,
  output logic                   degen_out,
  output logic [SUM_W-1:0]       sum
);
  localparam int CXW = 2 * CW + 3;
  localparam int SHW = $clog2(CXW);

  logic [CXW-1:0] mag4 [3];
  logic [CXW-1:0] mag5 [3];
  logic [CXW-1:0] orv;
  logic [CXW-1:0] norm [3];
  logic [SHW-1:0] shamt_next, shamt;
  logic [MAG_W-1:0] m6 [3];
  logic [MAG_W-1:0] m7 [3];
  logic [2*MAG_W-1:0] sq [3];
  logic [2:0] n4, n5, n6, n7;
  logic d5, d6, d7;
  logic [4:0] v;

  assign orv = mag4[0] | mag4[1] | mag4[2];

  always_comb begin
    shamt_next = '0;
    for (int i = 0; i < CXW; i++) begin
      if (orv[i]) shamt_next = SHW'(CXW - 1 - i);
    end
    for (int l = 0; l < 3; l++) begin
      norm[l] = mag5[l] << shamt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], in_valid};
    end
  end
  assign out_valid = v[4];

  always_ff @(posedge clk) begin
    if (en) begin
      n4 <= {c2[CXW-1], c1[CXW-1], c0[CXW-1]};
      mag4[0] <= c0[CXW-1] ? CXW'(-c0) : CXW'(c0);
      mag4[1] <= c1[CXW-1] ? CXW'(-c1) : CXW'(c1);
      mag4[2] <= c2[CXW-1] ? CXW'(-c2) : CXW'(c2);
      mag5 <= mag4;
      n5 <= n4;
      d5 <= (orv == '0);
      shamt <= shamt_next;
      for (int l = 0; l < 3; l++) begin
        m6[l] <= norm[l][CXW-1 -: MAG_W];
      end
      n6 <= n5;
      d6 <= d5;
      m7 <= m6;
      n7 <= n6;
      d7 <= d6;
      for (int l = 0; l < 3; l++) begin
        sq[l] <= (2*MAG_W)'(m6[l]) * (2*MAG_W)'(m6[l]);
      end
      sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
      m_out <= {m7[2], m7[1], m7[0]};
      neg_out <= n7;
      degen_out <= d7;
    end
  end
endmodule
`default_nettype wire

### design/tun_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Carries an opaque sideband alongside; depends on tun_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tun_isqrt import tun_pkg::*; #(
  parameter int SW = 8
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               en,
  input  wire               in_valid,
  input  wire [SUM_W-1:0]   radicand,
  input  wire [SW-1:0]      side_in,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output logic [SW-1:0]     side_out
);
  localparam int TW = SUM_W + 2;

  logic [SUM_W-1:0]  rem  [ROOT_W+1];
  logic [ROOT_W-1:0] rt   [ROOT_W+1];
  logic [SW-1:0]     sd   [ROOT_W+1];
  logic              vl   [ROOT_W+1];

  assign rem[0] = radicand;
  assign rt[0]  = '0;
  assign sd[0]  = side_in;
  assign vl[0]  = in_valid;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam int BI = ROOT_W - 1 - k;
    logic [TW-1:0] trial;
    logic          fits;
    assign trial = TW'({rt[k], 2'b01}) << (2 * BI);
    assign fits  = {2'b00, rem[k]} >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k+1] <= 1'b0;
      end else if (en) begin
        vl[k+1] <= vl[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= fits ? SUM_W'({2'b00, rem[k]} - trial) : rem[k];
        rt[k+1]  <= {rt[k][ROOT_W-2:0], fits};
        sd[k+1]  <= sd[k];
      end
    end
  end

  assign out_valid = vl[ROOT_W];
  assign root      = rt[ROOT_W];
  assign side_out  = sd[ROOT_W];
endmodule
`default_nettype wire

### design/tun_div.sv
// Three-lane restoring divider, one quotient bit per stage, plus
// sign, degenerate masking and the output register. Depends on tun_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tun_div import tun_pkg::*; #(
  parameter int NW = 32
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                en,
  input  wire                in_valid,
  input  wire [3*MAG_W-1:0]  m_in,
  input  wire [2:0]          neg_in,
  input  wire                degen_in,
  input  wire [ROOT_W-1:0]   q_in,
  output logic               out_valid,
  output logic [3*NW-1:0]    normal,
  output logic               degenerate
);
  localparam int F    = NW - 2;
  localparam int NS   = F + 1;
  localparam int NUMW = F + MAG_W + 2;
  localparam int RW   = NUMW + NS;
  localparam int DVW  = ROOT_W + 1;

  logic [NUMW-1:0] rem [NS+1][3];
  logic [NS-1:0]   quo [NS+1][3];
  logic [DVW-1:0]  dv  [NS+1];
  logic [2:0]      ng  [NS+1];
  logic            dg  [NS+1];
  logic            vl  [NS+1];
  logic [NW-1:0]   res [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rem[0][l] = {m_in[l*MAG_W +: MAG_W], {(F+1){1'b0}}} + NUMW'(q_in);
      quo[0][l] = '0;
    end
  end
  assign dv[0] = {q_in, 1'b0};
  assign ng[0] = neg_in;
  assign dg[0] = degen_in;
  assign vl[0] = in_valid;

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam int SH = NS - 1 - k;
    logic [RW-1:0] dsh;
    logic [2:0]    fits;
    assign dsh = RW'(dv[k]) << SH;
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        fits[l] = RW'(rem[k][l]) >= dsh;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k+1] <= 1'b0;
      end else if (en) begin
        vl[k+1] <= vl[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          rem[k+1][l] <= fits[l] ? NUMW'(RW'(rem[k][l]) - dsh) : rem[k][l];
          quo[k+1][l] <= {quo[k][l][NS-2:0], fits[l]};
        end
        dv[k+1] <= dv[k];
        ng[k+1] <= ng[k];
        dg[k+1] <= dg[k];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dg[NS]) res[l] = '0;
      else if (ng[NS][l]) res[l] = -NW'(quo[NS][l]);
      else res[l] = NW'(quo[NS][l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vl[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      normal     <= {res[2], res[1], res[0]};
      degenerate <= dg[NS];
    end
  end
endmodule
`default_nettype wire

### design/triangle_unit_normal.sv
// Top level of the triangle unit normal block.
// Depends on tun_pkg, tun_cross, tun_norm, tun_isqrt and tun_div.
//
// Usage:
//   Slave channel s_*: one transaction per triangle (tuser = 1) or per pair
//   of direction vectors (tuser = 0). tdata carries nine signed Q16.16
//   coordinates. Master channel m_*: one transaction per input, in order,
//   with the unit normal as three signed Q2.30 components and a degenerate
//   flag in tuser, set (with all components zero) for a zero cross product.
// Throughput: one transaction per cycle while the output is not stalled.
// Pipeline, from input to output: cross product, normalization and the
//   sum of squares, square root (one bit per stage), divider (one
//   quotient bit per stage per lane) and an output register.
// Stall: the whole pipeline advances together; while m_tvalid is high and
//   m_tready low every stage holds and s_tready is low, so nothing is lost
//   or repeated. The output register frees as soon as it is taken.
// Reset: rst clears all valid bits; the pipeline comes up empty.
`timescale 1ns / 1ps
`default_nettype none
module triangle_unit_normal import tun_pkg::*; #(
  parameter int COORD_WIDTH  = 32,
  parameter int NORMAL_WIDTH = 32
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  s_tvalid,
  output logic s_tready,
  // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z from bit 0 up
  input  wire  [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  // kind
  input  wire  s_tuser,
  output logic m_tvalid,
  input  wire  m_tready,
  // normal_x, normal_y, normal_z from bit 0 up
  output logic [((3*NORMAL_WIDTH+7)/8)*8-1:0] m_tdata,
  // degenerate
  output logic m_tuser
);
  localparam int CXW   = 2 * COORD_WIDTH + 3;
  localparam int ODW   = ((3*NORMAL_WIDTH+7)/8)*8;
  localparam int SIDEW = 3 * MAG_W + 4;

  logic en;
  logic cr_valid;
  logic signed [CXW-1:0] c0, c1, c2;
  logic nm_valid;
  logic [3*MAG_W-1:0] nm_m;
  logic [2:0] nm_neg;
  logic nm_degen;
  logic [SUM_W-1:0] nm_sum;
  logic sq_valid;
  logic [ROOT_W-1:0] sq_root;
  logic [SIDEW-1:0] sq_side;
  logic [3*NORMAL_WIDTH-1:0] normal;

  // whole-pipeline advance: output register empty or being drained
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  tun_cross #(.CW(COORD_WIDTH)) u_cross (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid),
    .kind(s_tuser),
    .pts(s_tdata[9*COORD_WIDTH-1:0]),
    .out_valid(cr_valid),
    .c0(c0), .c1(c1), .c2(c2)
  );

  tun_norm #(.CW(COORD_WIDTH)) u_norm (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(cr_valid),
    .c0(c0), .c1(c1), .c2(c2),
    .out_valid(nm_valid),
    .m_out(nm_m),
    .neg_out(nm_neg),
    .degen_out(nm_degen),
    .sum(nm_sum)
  );

  tun_isqrt #(.SW(SIDEW)) u_isqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(nm_valid),
    .radicand(nm_sum),
    .side_in({nm_degen, nm_neg, nm_m}),
    .out_valid(sq_valid),
    .root(sq_root),
    .side_out(sq_side)
  );

  tun_div #(.NW(NORMAL_WIDTH)) u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(sq_valid),
    .m_in(sq_side[3*MAG_W-1:0]),
    .neg_in(sq_side[3*MAG_W +: 3]),
    .degen_in(sq_side[SIDEW-1]),
    .q_in(sq_root),
    .out_valid(m_tvalid),
    .normal(normal),
    .degenerate(m_tuser)
  );

  assign m_tdata = ODW'(normal);
endmodule
`default_nettype wire
